// File: hw/rtl/motor_command_frame_encoder_assert.svh
// Assertion macros shared by the motor command frame encoder RTL.
`ifndef MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MCFE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MCFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mcfe_pkg.sv
// Types and constants of the motor command frame encoder.
package mcfe_pkg;

   // channel field widths
   localparam int ACT_W   = 2;
   localparam int NODE_W  = 7;
   localparam int VAL_W   = 32;
   localparam int ID_W    = 11;
   localparam int CSR_IDX_W = 3;

   // quantizer lanes
   localparam int NUM_LANES  = 5;
   localparam int LANE_POS   = 0;
   localparam int LANE_VEL   = 1;
   localparam int LANE_KP    = 2;
   localparam int LANE_KD    = 3;
   localparam int LANE_TOR   = 4;

   // divider geometry: every lane yields 16 quotient bits
   localparam int SPAN_W     = 32;
   localparam int QBITS      = 16;
   localparam int SHORT_BITS = 12;
   localparam int NUM_W      = SPAN_W + QBITS;

   // actions
   localparam logic [ACT_W-1:0] ACT_MOTION  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_ZERO    = 2'd3;

   // frame constants
   localparam logic [ID_W-1:0] CMD_ID_BASE  = 11'd512;
   localparam logic [7:0]      BYTE_FILL    = 8'hFF;
   localparam logic [7:0]      CODE_ENABLE  = 8'hFC;
   localparam logic [7:0]      CODE_DISABLE = 8'hFD;
   localparam logic [7:0]      CODE_ZERO    = 8'hFE;

   // fixed lower limits of the gains
   localparam logic signed [VAL_W-1:0] STIFF_MIN = 32'sd0;
   localparam logic signed [VAL_W-1:0] DAMP_MIN  = 32'sd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POS_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POS_MAX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STIFF_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DAMP_MAX   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_MIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_MAX = 3'd7;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [NODE_W-1:0]        node_id;
      logic signed [VAL_W-1:0]  target_pos;
      logic signed [VAL_W-1:0]  target_vel;
      logic signed [VAL_W-1:0]  stiffness;
      logic signed [VAL_W-1:0]  damping;
      logic signed [VAL_W-1:0]  feed_torque;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] frame_id;
      logic [7:0]      byte0;
      logic [7:0]      byte1;
      logic [7:0]      byte2;
      logic [7:0]      byte3;
      logic [7:0]      byte4;
      logic [7:0]      byte5;
      logic [7:0]      byte6;
      logic [7:0]      byte7;
   } rsp_type;

   // word context carried alongside the divider lanes
   typedef struct packed {
      logic [ACT_W-1:0]     action;
      logic [NODE_W-1:0]    node_id;
      logic [NUM_LANES-1:0] span_ok;
   } meta_type;

   // partial remainder and numerator/quotient shift word of one lane
   typedef struct packed {
      logic [SPAN_W-1:0] r;
      logic [QBITS-1:0]  w;
   } lane_type;

endpackage

// File: hw/rtl/mcfe_div_pipe.sv
// Sixteen-stage restoring divider pipeline shared by the five quantizer lanes.
module mcfe_div_pipe (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  mcfe_pkg::lane_type [mcfe_pkg::NUM_LANES-1:0] in_lane,
   input  mcfe_pkg::meta_type in_meta,
   input  logic [mcfe_pkg::NUM_LANES-1:0][mcfe_pkg::SPAN_W-1:0] span,
   output logic out_valid,
   input  logic out_ready,
   output logic [mcfe_pkg::NUM_LANES-1:0][mcfe_pkg::QBITS-1:0] out_quo,
   output mcfe_pkg::meta_type out_meta
);

   localparam int STAGES = mcfe_pkg::QBITS;
   localparam int NL     = mcfe_pkg::NUM_LANES;
   localparam int SW     = mcfe_pkg::SPAN_W;
   localparam int QB     = mcfe_pkg::QBITS;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;
   mcfe_pkg::lane_type [NL-1:0] lane_ff [STAGES];
   mcfe_pkg::meta_type          meta_ff [STAGES];

   assign en[STAGES] = out_ready;
   assign in_ready   = en[0];

   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         logic                        src_v;
         mcfe_pkg::lane_type [NL-1:0] src_lane;
         mcfe_pkg::meta_type          src_meta;
         mcfe_pkg::lane_type [NL-1:0] lane_in;

         if (k == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_lane = in_lane;
            assign src_meta = in_meta;
         end else begin : g_next
            assign src_v    = v_ff[k-1];
            assign src_lane = lane_ff[k-1];
            assign src_meta = meta_ff[k-1];
         end

         // one quotient bit per lane: shift in the next numerator bit, try subtract
         always_comb begin
            logic [SW:0] trial;
            logic [SW:0] diff;
            logic        ge;
            for (int l = 0; l < NL; l++) begin
               trial = {src_lane[l].r, src_lane[l].w[QB-1]};
               diff  = trial - {1'b0, span[l]};
               ge    = (trial >= {1'b0, span[l]});
               lane_in[l].r = ge ? diff[SW-1:0] : trial[SW-1:0];
               lane_in[l].w = {src_lane[l].w[QB-2:0], ge};
            end
         end

         assign en[k] = !v_ff[k] || en[k+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= src_v;
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               lane_ff[k] <= lane_in;
               meta_ff[k] <= src_meta;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         out_quo[l] = lane_ff[STAGES-1][l].w;
      end
   end

   `include "motor_command_frame_encoder_assert.svh"

   // an empty tail stage opens the whole chain
   `MCFE_ASSERT_NOW(a_ready_when_tail_empty, !v_ff[STAGES-1], in_ready, "div: stall with empty tail")

   // a held tail word is neither dropped nor replaced
   `MCFE_ASSERT_NEXT(a_tail_holds, v_ff[STAGES-1] && !out_ready, v_ff[STAGES-1] && $stable(lane_ff[STAGES-1]), "div: tail word lost")

   genvar ka, la;
   generate
      for (ka = 0; ka < STAGES; ka++) begin : g_chk_stage
         for (la = 0; la < NL; la++) begin : g_chk_lane
            // partial remainder stays below the divisor on live lanes
            `MCFE_ASSERT_NOW(a_rem_bound, v_ff[ka] && meta_ff[ka].span_ok[la], lane_ff[ka][la].r < span[la], "div: remainder not below span")
         end
      end
   endgenerate

endmodule

// File: hw/rtl/motor_command_frame_encoder.sv
// Motor command frame encoder: one 8-byte CAN motor frame per request word.
//
// Each accepted request word yields exactly one response word, in order.
// A motion word (action 0) clamps position, velocity, stiffness, damping and
// torque to their configured limits and maps each onto an unsigned code
// floor((x - min) * (2^bits - 1) / (max - min)), 16 bits for position and
// 12 bits for the rest; a limit pair whose max is not above its min gives
// code 0. Codes are packed big-endian into byte0..byte7 and the frame id is
// CMD_ID_BASE + node_id (11-bit wrap). Enable, disable and set-zero words give
// seven 0xFF bytes then 0xFC, 0xFD or 0xFE, with frame id = node_id.
// Throughput is one word per clock while rsp_ready stays high. A word
// passes clamp, offset, numerator scaling, 16 stages of a one-bit-per-stage
// restoring divider (all five lanes side by side), then the output
// register. Every stage carries its own valid bit and a stage takes a new
// word whenever the stage after it is empty or moving, so bubbles collapse
// and a stalled response does not block the front until the pipeline is
// full. Limit registers are written through csr_* by the user only while the
// block is idle (not enforced in the block) and reset to nominal motor limits.
module motor_command_frame_encoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mcfe_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mcfe_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wen,
   input  logic [mcfe_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mcfe_pkg::VAL_W-1:0]             csr_wdata
);

   localparam int NL = mcfe_pkg::NUM_LANES;
   localparam int VW = mcfe_pkg::VAL_W;
   localparam int SW = mcfe_pkg::SPAN_W;
   localparam int QB = mcfe_pkg::QBITS;
   localparam int SB = mcfe_pkg::SHORT_BITS;
   localparam int NW = mcfe_pkg::NUM_W;

   // ---------------------------------------------------------------- limits
   logic signed [VW-1:0] pos_min_ff, pos_max_ff, vel_min_ff, vel_max_ff;
   logic signed [VW-1:0] torque_min_ff, torque_max_ff;
   logic [VW-2:0]        stiff_max_ff, damp_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_min_ff    <= -32'sd821248;
         pos_max_ff    <= 32'sd821248;
         vel_min_ff    <= -32'sd2949120;
         vel_max_ff    <= 32'sd2949120;
         stiff_max_ff  <= 31'd32768000;
         damp_max_ff   <= 31'd327680;
         torque_min_ff <= -32'sd1179648;
         torque_max_ff <= 32'sd1179648;
      end else if (csr_wen) begin
         case (csr_index)
            mcfe_pkg::REG_POS_MIN:    pos_min_ff    <= csr_wdata;
            mcfe_pkg::REG_POS_MAX:    pos_max_ff    <= csr_wdata;
            mcfe_pkg::REG_VEL_MIN:    vel_min_ff    <= csr_wdata;
            mcfe_pkg::REG_VEL_MAX:    vel_max_ff    <= csr_wdata;
            mcfe_pkg::REG_STIFF_MAX:  stiff_max_ff  <= csr_wdata[VW-2:0];
            mcfe_pkg::REG_DAMP_MAX:   damp_max_ff   <= csr_wdata[VW-2:0];
            mcfe_pkg::REG_TORQUE_MIN: torque_min_ff <= csr_wdata;
            mcfe_pkg::REG_TORQUE_MAX: torque_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-lane limits, span and live flag; the user keeps limits static while words fly (not enforced)
   logic signed [VW-1:0] lo [NL];
   logic signed [VW-1:0] hi [NL];
   logic [NL-1:0][SW-1:0] span;
   logic [NL-1:0]         span_ok;

   always_comb begin
      logic signed [VW:0] width;
      lo[mcfe_pkg::LANE_POS] = pos_min_ff;
      hi[mcfe_pkg::LANE_POS] = pos_max_ff;
      lo[mcfe_pkg::LANE_VEL] = vel_min_ff;
      hi[mcfe_pkg::LANE_VEL] = vel_max_ff;
      lo[mcfe_pkg::LANE_KP]  = mcfe_pkg::STIFF_MIN;
      hi[mcfe_pkg::LANE_KP]  = $signed({1'b0, stiff_max_ff});
      lo[mcfe_pkg::LANE_KD]  = mcfe_pkg::DAMP_MIN;
      hi[mcfe_pkg::LANE_KD]  = $signed({1'b0, damp_max_ff});
      lo[mcfe_pkg::LANE_TOR] = torque_min_ff;
      hi[mcfe_pkg::LANE_TOR] = torque_max_ff;
      for (int l = 0; l < NL; l++) begin
         width      = {hi[l][VW-1], hi[l]} - {lo[l][VW-1], lo[l]};
         span[l]    = width[SW-1:0];
         span_ok[l] = (hi[l] > lo[l]);
      end
   end

   // ------------------------------------------------------ handshake chain
   logic en1, en2, en3, en_o;
   logic div_in_ready, div_out_valid;
   logic v1_ff, v2_ff, v3_ff, vo_ff;

   assign en_o      = !vo_ff || rsp_ready;
   assign en3       = !v3_ff || div_in_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1)  v1_ff <= req_valid;
         if (en2)  v2_ff <= v1_ff;
         if (en3)  v3_ff <= v2_ff;
         if (en_o) vo_ff <= div_out_valid;
      end
   end

   // ------------------------------------------------------- stage 1: clamp
   logic signed [VW-1:0] x [NL];
   logic signed [VW-1:0] xc1_in [NL];
   logic signed [VW-1:0] xc1_ff [NL];
   mcfe_pkg::meta_type   meta1_in, meta1_ff;

   always_comb begin
      x[mcfe_pkg::LANE_POS] = req_data.target_pos;
      x[mcfe_pkg::LANE_VEL] = req_data.target_vel;
      x[mcfe_pkg::LANE_KP]  = req_data.stiffness;
      x[mcfe_pkg::LANE_KD]  = req_data.damping;
      x[mcfe_pkg::LANE_TOR] = req_data.feed_torque;
      for (int l = 0; l < NL; l++) begin
         if (x[l] < lo[l]) begin
            xc1_in[l] = lo[l];
         end else if (x[l] > hi[l]) begin
            xc1_in[l] = hi[l];
         end else begin
            xc1_in[l] = x[l];
         end
      end
      meta1_in.action  = req_data.action;
      meta1_in.node_id = req_data.node_id;
      meta1_in.span_ok = span_ok;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         xc1_ff   <= xc1_in;
         meta1_ff <= meta1_in;
      end
   end

   // ----------------------------------------------- stage 2: offset from min
   logic [SW-1:0]      diff2_in [NL];
   logic [SW-1:0]      diff2_ff [NL];
   mcfe_pkg::meta_type meta2_ff;

   always_comb begin
      logic signed [VW:0] off;
      for (int l = 0; l < NL; l++) begin
         off         = {xc1_ff[l][VW-1], xc1_ff[l]} - {lo[l][VW-1], lo[l]};
         diff2_in[l] = off[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         diff2_ff <= diff2_in;
         meta2_ff <= meta1_ff;
      end
   end

   // -------------------------------------- stage 3: numerator diff*(2^b - 1)
   // 12-bit lanes are scaled by 16 so all lanes divide to 16 quotient bits;
   // their code is the top 12 bits of that quotient.
   mcfe_pkg::lane_type [NL-1:0] lane3_in, lane3_ff;
   mcfe_pkg::meta_type          meta3_ff;

   always_comb begin
      logic [NW-1:0] num;
      for (int l = 0; l < NL; l++) begin
         if (l == mcfe_pkg::LANE_POS) begin
            num = {diff2_ff[l], {QB{1'b0}}} - {{QB{1'b0}}, diff2_ff[l]};
         end else begin
            num = {diff2_ff[l], {QB{1'b0}}}
                  - {{SB{1'b0}}, diff2_ff[l], {(QB - SB){1'b0}}};
         end
         lane3_in[l].r = num[NW-1:QB];
         lane3_in[l].w = num[QB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         lane3_ff <= lane3_in;
         meta3_ff <= meta2_ff;
      end
   end

   // ------------------------------------------------------------- divider
   logic [NL-1:0][QB-1:0] quo;
   mcfe_pkg::meta_type    div_meta;

   mcfe_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (div_in_ready),
      .in_lane   (lane3_ff),
      .in_meta   (meta3_ff),
      .span      (span),
      .out_valid (div_out_valid),
      .out_ready (en_o),
      .out_quo   (quo),
      .out_meta  (div_meta)
   );

   // --------------------------------------------------- frame assembly
   mcfe_pkg::rsp_type          rsp_in, rsp_ff;
   logic [mcfe_pkg::ACT_W-1:0] act_o_ff;

   always_comb begin
      logic [QB-1:0] p;
      logic [SB-1:0] v, kp, kd, t;
      p  = div_meta.span_ok[mcfe_pkg::LANE_POS] ? quo[mcfe_pkg::LANE_POS] : '0;
      v  = div_meta.span_ok[mcfe_pkg::LANE_VEL] ? quo[mcfe_pkg::LANE_VEL][QB-1:QB-SB] : '0;
      kp = div_meta.span_ok[mcfe_pkg::LANE_KP]  ? quo[mcfe_pkg::LANE_KP][QB-1:QB-SB]  : '0;
      kd = div_meta.span_ok[mcfe_pkg::LANE_KD]  ? quo[mcfe_pkg::LANE_KD][QB-1:QB-SB]  : '0;
      t  = div_meta.span_ok[mcfe_pkg::LANE_TOR] ? quo[mcfe_pkg::LANE_TOR][QB-1:QB-SB] : '0;

      rsp_in.frame_id = {{(mcfe_pkg::ID_W - mcfe_pkg::NODE_W){1'b0}}, div_meta.node_id};
      rsp_in.byte0    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte1    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte2    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte3    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte4    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte5    = mcfe_pkg::BYTE_FILL;
      rsp_in.byte6    = mcfe_pkg::BYTE_FILL;
      case (div_meta.action)
         mcfe_pkg::ACT_ENABLE:  rsp_in.byte7 = mcfe_pkg::CODE_ENABLE;
         mcfe_pkg::ACT_DISABLE: rsp_in.byte7 = mcfe_pkg::CODE_DISABLE;
         mcfe_pkg::ACT_ZERO:    rsp_in.byte7 = mcfe_pkg::CODE_ZERO;
         default: begin
            // motion: command id and packed codes
            rsp_in.frame_id = mcfe_pkg::CMD_ID_BASE
                              + {{(mcfe_pkg::ID_W - mcfe_pkg::NODE_W){1'b0}},
                                 div_meta.node_id};
            rsp_in.byte0 = p[15:8];
            rsp_in.byte1 = p[7:0];
            rsp_in.byte2 = v[11:4];
            rsp_in.byte3 = {v[3:0], kp[11:8]};
            rsp_in.byte4 = kp[7:0];
            rsp_in.byte5 = kd[11:4];
            rsp_in.byte6 = {kd[3:0], t[11:8]};
            rsp_in.byte7 = t[7:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         rsp_ff   <= rsp_in;
         act_o_ff <= div_meta.action;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

   `include "motor_command_frame_encoder_assert.svh"

   // an empty output register means every stage can move
   `MCFE_ASSERT_NOW(a_ready_when_out_empty, !vo_ff, req_ready, "top: front stalled with output empty")

   // special frames carry the bare node id and fill bytes
   `MCFE_ASSERT_NOW(a_special_frame, vo_ff && act_o_ff != mcfe_pkg::ACT_MOTION, rsp_ff.frame_id[mcfe_pkg::ID_W-1:mcfe_pkg::NODE_W] == '0 && rsp_ff.byte0 == mcfe_pkg::BYTE_FILL, "top: bad special frame")

   // a stalled clamp stage keeps its word
   `MCFE_ASSERT_NEXT(a_stage1_holds, v1_ff && !en2, v1_ff && $stable(meta1_ff), "top: clamp stage word lost")

endmodule

// File: verif/tb_motor_command_frame_encoder.sv
// Self-checking testbench for the motor command frame encoder.
module tb_motor_command_frame_encoder;
   import mcfe_pkg::*;

   // clock, reset and DUT ports; everything starts at a known value
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0]  csr_wdata = '0;

   // shadow copy of the limit registers, at their reset values
   logic signed [31:0] lim_pos_min    = -32'sd821248;
   logic signed [31:0] lim_pos_max    = 32'sd821248;
   logic signed [31:0] lim_vel_min    = -32'sd2949120;
   logic signed [31:0] lim_vel_max    = 32'sd2949120;
   logic        [30:0] lim_stiff_max  = 31'd32768000;
   logic        [30:0] lim_damp_max   = 31'd327680;
   logic signed [31:0] lim_torque_min = -32'sd1179648;
   logic signed [31:0] lim_torque_max = 32'sd1179648;

   req_type cmd_words[$];    // command words waiting to be offered
   rsp_type frames_due[$];   // predicted frames, oldest first

   int  mismatches = 0;
   int  words_sent = 0;
   int  send_gap   = 0;
   int  stall_left = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;
   bit  no_idle    = 1'b0;   // when set, neither side inserts gaps

   motor_command_frame_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Linear map of a clamped value onto an unsigned code:
   // floor((x - lo) * (2^bits - 1) / (hi - lo)), zero when the span is empty.
   // The product stays under 2^48, so 64-bit math is exact.
   function automatic logic [15:0] scale_code(longint x, longint lo, longint hi, int bits);
      longint unsigned full, span, diff;
      longint          xc;
      if (hi <= lo) return 16'd0;
      xc = x;
      if (xc < lo) xc = lo;
      else if (xc > hi) xc = hi;
      full = (longint'(1) << bits) - 1;
      span = hi - lo;
      diff = xc - lo;
      return 16'((diff * full) / span);
   endfunction

   // Expected frame for one command word under the current limits.
   function automatic rsp_type encode_frame(req_type w);
      rsp_type     f;
      logic [15:0] p, v, kp, kd, t;
      if (w.action == ACT_MOTION) begin
         p  = scale_code(w.target_pos, lim_pos_min, lim_pos_max, 16);
         v  = scale_code(w.target_vel, lim_vel_min, lim_vel_max, 12);
         kp = scale_code(w.stiffness, STIFF_MIN, longint'(lim_stiff_max), 12);
         kd = scale_code(w.damping, DAMP_MIN, longint'(lim_damp_max), 12);
         t  = scale_code(w.feed_torque, lim_torque_min, lim_torque_max, 12);
         // 11-bit id wraps naturally
         f.frame_id = CMD_ID_BASE + w.node_id;
         f.byte0 = p[15:8];
         f.byte1 = p[7:0];
         f.byte2 = v[11:4];
         f.byte3 = {v[3:0], kp[11:8]};
         f.byte4 = kp[7:0];
         f.byte5 = kd[11:4];
         f.byte6 = {kd[3:0], t[11:8]};
         f.byte7 = t[7:0];
      end else begin
         // special actions: node id alone, fill bytes, then the action code
         f.frame_id = {{(ID_W-NODE_W){1'b0}}, w.node_id};
         f.byte0 = BYTE_FILL;
         f.byte1 = BYTE_FILL;
         f.byte2 = BYTE_FILL;
         f.byte3 = BYTE_FILL;
         f.byte4 = BYTE_FILL;
         f.byte5 = BYTE_FILL;
         f.byte6 = BYTE_FILL;
         case (w.action)
            ACT_ENABLE:  f.byte7 = CODE_ENABLE;
            ACT_DISABLE: f.byte7 = CODE_DISABLE;
            default:     f.byte7 = CODE_ZERO;
         endcase
      end
      return f;
   endfunction

   // Gap length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // Field value aimed at the interesting spots of a limit pair: the limits,
   // one past them, the 32-bit extremes, inside the range, or anything.
   function automatic logic [31:0] pick_value(longint lo, longint hi);
      longint v;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = lo;
         2: v = hi;
         3: v = lo - 1;
         4: v = hi + 1;
         5: v = {32'd0, ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)};
         default: begin
            if (hi > lo) v = lo + longint'($urandom) % (hi - lo + 1);
            else v = $urandom;
         end
      endcase
      return v[31:0];
   endfunction

   function automatic req_type make_word(logic [1:0] act, logic [6:0] node,
                                         logic [31:0] p, logic [31:0] v,
                                         logic [31:0] kp, logic [31:0] kd,
                                         logic [31:0] t);
      req_type w;
      w.action      = act;
      w.node_id     = node;
      w.target_pos  = p;
      w.target_vel  = v;
      w.stiffness   = kp;
      w.damping     = kd;
      w.feed_torque = t;
      return w;
   endfunction

   // Random command word: mostly motion, the rest spread over the actions.
   function automatic req_type random_word();
      int r;
      logic [1:0] act;
      r = $urandom_range(0, 99);
      act = (r < 70) ? ACT_MOTION : (r < 80) ? ACT_ENABLE :
            (r < 90) ? ACT_DISABLE : ACT_ZERO;
      return make_word(act, 7'($urandom),
                       pick_value(lim_pos_min, lim_pos_max),
                       pick_value(lim_vel_min, lim_vel_max),
                       pick_value(0, longint'(lim_stiff_max)),
                       pick_value(0, longint'(lim_damp_max)),
                       pick_value(lim_torque_min, lim_torque_max));
   endfunction

   task automatic cmp_field(string fname, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // Compare one delivered frame against the oldest prediction.
   task automatic check_frame(rsp_type got);
      rsp_type want;
      if (frames_due.size() == 0) begin
         $display("%0t: unexpected frame: expected none, got %h", $time, got);
         mismatches++;
      end else begin
         want = frames_due.pop_front();
         cmp_field("frame_id", want.frame_id, got.frame_id);
         cmp_field("byte0", want.byte0, got.byte0);
         cmp_field("byte1", want.byte1, got.byte1);
         cmp_field("byte2", want.byte2, got.byte2);
         cmp_field("byte3", want.byte3, got.byte3);
         cmp_field("byte4", want.byte4, got.byte4);
         cmp_field("byte5", want.byte5, got.byte5);
         cmp_field("byte6", want.byte6, got.byte6);
         cmp_field("byte7", want.byte7, got.byte7);
      end
   endtask

   // One register write, issued on the next edge. The shadow copy is updated
   // right away: writes only happen with the pipeline empty. The caller
   // drops csr_wen after the last write.
   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_POS_MIN:    lim_pos_min    = val;
         REG_POS_MAX:    lim_pos_max    = val;
         REG_VEL_MIN:    lim_vel_min    = val;
         REG_VEL_MAX:    lim_vel_max    = val;
         REG_STIFF_MAX:  lim_stiff_max  = val[30:0];   // top bit not stored
         REG_DAMP_MAX:   lim_damp_max   = val[30:0];
         REG_TORQUE_MIN: lim_torque_min = val;
         default:        lim_torque_max = val;
      endcase
   endtask

   task automatic set_limits(logic [31:0] pmin, logic [31:0] pmax,
                             logic [31:0] vmin, logic [31:0] vmax,
                             logic [31:0] smax, logic [31:0] dmax,
                             logic [31:0] tmin, logic [31:0] tmax);
      write_limit(REG_POS_MIN, pmin);
      write_limit(REG_POS_MAX, pmax);
      write_limit(REG_VEL_MIN, vmin);
      write_limit(REG_VEL_MAX, vmax);
      write_limit(REG_STIFF_MAX, smax);
      write_limit(REG_DAMP_MAX, dmax);
      write_limit(REG_TORQUE_MIN, tmin);
      write_limit(REG_TORQUE_MAX, tmax);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Block is idle once nothing is queued, offered or still owed.
   task automatic wait_idle();
      @(negedge clock);
      while (cmd_words.size() != 0 || req_valid || frames_due.size() != 0)
         @(negedge clock);
   endtask

   // Driver: offers queued words, holds each until taken, and predicts the
   // frame at the edge where a word is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            frames_due.push_back(encode_frame(req_data));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cmd_words.size() != 0) begin
               req_data  <= cmd_words.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off, once: the receiver stops for well past the pipeline
   // depth while the sender keeps going, so the block fills and backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_sent >= 60) begin
         hold_left <= 150;
         hold_done <= 1'b1;
      end
   end

   // Monitor: checks each delivered frame and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_frame(rsp_data);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Stimulus and phases
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset limits: zero, both limits, one past
      // them, 32-bit extremes, negative gains, and every special action.
      @(negedge clock);
      cmd_words.push_back(make_word(ACT_MOTION, 7'd0, 0, 0, 0, 0, 0));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd127, -821248, -2949120, 0, 0,
                                    -1179648));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd85, 821248, 2949120, 32768000,
                                    327680, 1179648));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd42, -821249, -2949121, -1, -1,
                                    -1179649));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd1, 821249, 2949121, 32768001,
                                    327681, 1179649));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd42, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd126, 821247, 2949119, 32767999,
                                    327679, 1179647));
      cmd_words.push_back(make_word(ACT_MOTION, 7'd64, 12345, -67890, 16384000,
                                    163840, -500000));
      cmd_words.push_back(make_word(ACT_ENABLE, 7'd0, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
      cmd_words.push_back(make_word(ACT_DISABLE, 7'd127, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      cmd_words.push_back(make_word(ACT_ZERO, 7'd64, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      cmd_words.push_back(make_word(ACT_ENABLE, 7'd127, 0, 0, 0, 0, 0));
      cmd_words.push_back(make_word(ACT_ZERO, 7'd0, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
      cmd_words.push_back(make_word(ACT_DISABLE, 7'd3, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
      // random words still at reset limits; the hold-off lands in here
      repeat (100) cmd_words.push_back(random_word());
      wait_idle();

      // Extremes: full 32-bit position range, inverted velocity range,
      // widest stiffness, empty damping and torque ranges. Run gap-free.
      set_limits(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h0, 32'd5, 32'd5);
      no_idle = 1'b1;
      @(negedge clock);
      repeat (100) cmd_words.push_back(random_word());
      wait_idle();
      no_idle = 1'b0;

      // Narrowest spans, a masked top bit on damping, torque at the bottom.
      set_limits(32'hFFFF_FFFF, 32'h0, 32'd100, 32'd101, 32'd1, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h8000_0FFF);
      @(negedge clock);
      repeat (100) cmd_words.push_back(random_word());
      wait_idle();

      // Raw random limits: about half the position, velocity and torque pairs end up inverted.
      set_limits($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      @(negedge clock);
      repeat (100) cmd_words.push_back(random_word());
      wait_idle();

      // Random well-ordered limits around zero.
      set_limits(-$urandom_range(0, 1 << 24), $urandom_range(1, 1 << 24),
                 -$urandom_range(0, 1 << 24), $urandom_range(1, 1 << 24),
                 $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                 -$urandom_range(0, 1 << 24), $urandom_range(1, 1 << 24));
      @(negedge clock);
      repeat (100) cmd_words.push_back(random_word());
      wait_idle();

      // drain margin past the pipeline depth, catches stray frames
      repeat (30) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
